### hdl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes of the positional array list
// Operation codes, status codes, cell command codes and port field widths.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [1:0]          cell_op_type;

   // list operations
   localparam func_type FUNC_APPEND    = 3'd0;
   localparam func_type FUNC_PREPEND   = 3'd1;
   localparam func_type FUNC_REM_FIRST = 3'd2;
   localparam func_type FUNC_REM_LAST  = 3'd3;
   localparam func_type FUNC_SET       = 3'd4;
   localparam func_type FUNC_INSERT    = 3'd5;
   localparam func_type FUNC_REMOVE_AT = 3'd6;
   localparam func_type FUNC_READ      = 3'd7;

   // completion status
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;
   localparam status_type STATUS_EMPTY = 2'd3;

   // per-cell command broadcast along the row
   localparam cell_op_type CELL_HOLD  = 2'd0;
   localparam cell_op_type CELL_LOAD  = 2'd1;  // write cell at index
   localparam cell_op_type CELL_OPEN  = 2'd2;  // shift up from index, load gap
   localparam cell_op_type CELL_CLOSE = 2'd3;  // shift down from index

endpackage

### hdl/pal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_if: request and response channel interfaces
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface pal_req_if import pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [POS_W-1:0]         pos;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, func, pos, value, input ready);
   modport sink   (input valid, func, pos, value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic [COUNT_W-1:0]       count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, read_value, count, status, input ready);
   modport sink   (input valid, read_value, count, status, output ready);
endinterface

### hdl/positional_array_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_top: bounded ordered list with indexed insert/remove
// Row of CAPACITY cells; a shared control decodes each request transaction.
// ----------------------------------------------------------------------------
// The list is a row of CAPACITY cells, one per entry. Every request
// transaction is decoded in the cycle it is accepted into a single command
// (hold, load at index, open a gap at index, close a gap at index) that is
// broadcast to all cells; each cell compares its own index with the command
// index and either holds, loads the new value, or takes its left or right
// neighbor, so an insert or remove at any position updates the whole row at once.
// A read selects the addressed cell through an AND-OR of the cell taps.
// Every transaction yields exactly one response in the cycle after acceptance,
// held in an output register, and a new request is taken every cycle while
// that register is empty or being drained: throughput is one transaction
// per cycle unless the response stalls. Stored entries have no reset; only
// entries below the element count are ever read. Status is ok, position out
// of range (checked before full for insert), full, or empty.
// ----------------------------------------------------------------------------
module positional_array_list_top import pal_pkg::*; #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_chan,
   pal_rsp_if.source rsp_chan
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   typedef struct packed {
      cell_op_type            op;
      logic [IDX_W-1:0]       at;
      logic [VALUE_WIDTH-1:0] value;
   } cmd_type;

   // --- state --------------------------------------------------------------
   logic [CNT_W-1:0]         cnt_ff,        cnt_in;
   logic                     rsp_valid_ff,  rsp_valid_in;
   logic signed [DATA_W-1:0] read_value_ff, read_value_in;
   logic [COUNT_W-1:0]       count_ff,      count_in;
   status_type               status_ff,     status_in;

   // --- decode -------------------------------------------------------------
   logic                     accept;
   cmd_type                  cmd;
   cell_op_type              op_sel;
   logic [IDX_W-1:0]         at_sel;
   logic                     rd_ok;
   logic [CNT_W-1:0]         cnt_next;
   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         cnt_x;
   logic                     full;
   logic                     empty;
   logic [63:0]              value_wide;
   logic [VALUE_WIDTH-1:0]   tap_or;
   logic [63:0]              rd_wide;

   logic [VALUE_WIDTH-1:0]   cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0]   tap_value  [CAPACITY];

   // one response register: take a new transaction whenever it is free or
   // being emptied this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign pos_x = CMP_W'(req_chan.pos);
   assign cnt_x = CMP_W'(cnt_ff);
   assign full  = (cnt_ff == CNT_FULL);
   assign empty = (cnt_ff == '0);

   // input value is 32-bit signed; kept in its low VALUE_WIDTH bits
   assign value_wide = 64'(req_chan.value);

   always_comb begin
      op_sel    = CELL_HOLD;
      at_sel    = pos_x[IDX_W-1:0];
      status_in = STATUS_OK;
      cnt_next  = cnt_ff;
      rd_ok     = 1'b0;
      case (req_chan.func)
         FUNC_APPEND: begin
            if (full) status_in = STATUS_FULL;
            else begin
               op_sel   = CELL_LOAD;
               at_sel   = cnt_ff[IDX_W-1:0];
               cnt_next = cnt_ff + 1'b1;
            end
         end
         FUNC_PREPEND: begin
            if (full) status_in = STATUS_FULL;
            else begin
               op_sel   = CELL_OPEN;
               at_sel   = '0;
               cnt_next = cnt_ff + 1'b1;
            end
         end
         FUNC_REM_FIRST: begin
            if (empty) status_in = STATUS_EMPTY;
            else begin
               op_sel   = CELL_CLOSE;
               at_sel   = '0;
               cnt_next = cnt_ff - 1'b1;
            end
         end
         FUNC_REM_LAST: begin
            if (empty) status_in = STATUS_EMPTY;
            else       cnt_next  = cnt_ff - 1'b1;
         end
         FUNC_SET: begin
            if (pos_x >= cnt_x) status_in = STATUS_RANGE;
            else                op_sel    = CELL_LOAD;
         end
         FUNC_INSERT: begin
            // range is checked before full
            if (pos_x > cnt_x) status_in = STATUS_RANGE;
            else if (full)     status_in = STATUS_FULL;
            else begin
               op_sel   = CELL_OPEN;
               cnt_next = cnt_ff + 1'b1;
            end
         end
         FUNC_REMOVE_AT: begin
            if (empty)               status_in = STATUS_EMPTY;
            else if (pos_x >= cnt_x) status_in = STATUS_RANGE;
            else begin
               op_sel   = CELL_CLOSE;
               cnt_next = cnt_ff - 1'b1;
            end
         end
         FUNC_READ: begin
            if (pos_x >= cnt_x) status_in = STATUS_RANGE;
            else                rd_ok     = 1'b1;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // cells act only on an accepted transaction
   assign cmd.op    = accept ? op_sel : CELL_HOLD;
   assign cmd.at    = at_sel;
   assign cmd.value = value_wide[VALUE_WIDTH-1:0];

   // --- cell row -----------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_v;
      logic [VALUE_WIDTH-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;            // never taken: no cell sits above a gap at -1
      end else begin : g_left
         assign left_v = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[i]; // top entry falls past the count anyway
      end else begin : g_right
         assign right_v = cell_value[i+1];
      end

      pal_cell #(
         .INDEX       (i),
         .IDX_W       (IDX_W),
         .VALUE_WIDTH (VALUE_WIDTH),
         .cmd_type    (cmd_type)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .cell_value  (cell_value[i]),
         .tap_value   (tap_value[i])
      );
   end

   // read select: OR of taps, only the addressed cell is nonzero
   always_comb begin
      tap_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         tap_or = tap_or | tap_value[k];
      end
   end

   assign rd_wide = 64'(signed'(tap_or));

   // --- response register ---------------------------------------------------
   assign cnt_in        = accept ? cnt_next : cnt_ff;
   assign rsp_valid_in  = accept ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   assign read_value_in = rd_ok ? signed'(rd_wide[DATA_W-1:0]) : '0;
   assign count_in      = COUNT_W'(cnt_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = read_value_ff;
   assign rsp_chan.count      = count_ff;
   assign rsp_chan.status     = status_ff;

`ifndef SYNTHESIS
   // element count never passes capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("element count above capacity");

   // a failed transaction leaves the count alone
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in != STATUS_OK) |=> cnt_ff == $past(cnt_ff))
      else $error("count changed on failed transaction");

   // reported count matches the internal count after the transaction
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == COUNT_W'(cnt_ff))
      else $error("response count differs from element count");

   // only reads return data
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.func != FUNC_READ) |=> read_value_ff == '0)
      else $error("nonzero read value on non-read transaction");

   // a stalled response blocks new requests
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while response stalled");
`endif

endmodule

### hdl/pal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell: one list entry
// Holds, loads, or takes its left or right neighbor per the broadcast command.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
   parameter int  INDEX       = 0,
   parameter int  IDX_W       = 6,
   parameter int  VALUE_WIDTH = 32,
   parameter type cmd_type    = logic
) (
   input  logic                   clock,
   input  cmd_type                cmd,
   input  logic [VALUE_WIDTH-1:0] left_value,
   input  logic [VALUE_WIDTH-1:0] right_value,
   output logic [VALUE_WIDTH-1:0] cell_value,
   output logic [VALUE_WIDTH-1:0] tap_value
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;
   logic                   hit;
   logic                   above;

   assign hit   = (cmd.at == MY_IDX);
   assign above = (MY_IDX > cmd.at);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_LOAD: begin
            if (hit) entry_in = cmd.value;
         end
         CELL_OPEN: begin
            if (above)    entry_in = left_value;
            else if (hit) entry_in = cmd.value;
         end
         CELL_CLOSE: begin
            if (above || hit) entry_in = right_value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_value = entry_ff;
   // AND-OR read tap: only the addressed cell drives a nonzero value
   assign tap_value  = hit ? entry_ff : '0;

endmodule
